### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clocked on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge
`define ASSERT_AT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hw/rtl/mtr_pkg.sv
`default_nettype none
package mtr_pkg;
    localparam int MAX_SAMPLES = 15;
    localparam int TABLE_DEPTH = 16;
    localparam int ADC_BITS    = 12;
    localparam int TEMP_W      = 16;
    localparam int FILL_W      = $clog2(MAX_SAMPLES + 1);
    localparam int SIDX_W      = $clog2(MAX_SAMPLES);
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);
    localparam int TSZ_W       = 5;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = TEMP_W + 1 + ADC_BITS + 1;
    localparam int DVD_W       = PROD_W;
    localparam int DCNT_W      = $clog2(DVD_W);

    localparam logic signed [TEMP_W-1:0] OFF_TEMPERATURE = -16'sd35;
    localparam logic [ADC_BITS-1:0]      OFF_MEDIAN      = 12'd3000;

    localparam logic CMD_TABLE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 2'd2;

    typedef struct packed {
        logic                      command;
        logic [3:0]                entry_index;
        logic [ADC_BITS-1:0]       entry_x;
        logic signed [TEMP_W-1:0]  entry_y;
        logic [ADC_BITS-1:0]       sample;
    } item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temperature;
        logic [ADC_BITS-1:0]       median;
    } result_t;

    typedef enum logic [2:0] {
        RS_FIRST,
        RS_LAST,
        RS_ONE,
        RS_NEXT,
        RS_PREV
    } rd_sel_t;

    typedef struct packed {
        logic    write_entry;
        logic    take_sample;
        logic    rank_step;
        logic    ld_first;
        logic    ld_last;
        logic    ld_hit;
        logic    ld_prev;
        logic    mul;
        logic    div_step;
        logic    calc;
        logic    emit;
        logic    emit_off;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic enabled;
        logic sample_ends;
        logic rank_found;
        logic ge_first;
        logic le_last;
        logic srch_hit;
        logic div_done;
    } dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/mtr_ctrl.sv
`default_nettype none
module mtr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            command,
    input  wire mtr_pkg::dp_stat_t st,
    output mtr_pkg::dp_cmd_t     cmd,
    output logic                 busy
);
    import mtr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_RANK = 10'b0000000010,
        ST_RD0  = 10'b0000000100,
        ST_RDL  = 10'b0000001000,
        ST_SRCH = 10'b0000010000,
        ST_PREV = 10'b0000100000,
        ST_MUL  = 10'b0001000000,
        ST_DIV  = 10'b0010000000,
        ST_CALC = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // sample taken in idle with the sensor off / closing a burst
    logic off_take;
    logic last_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RS_FIRST;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_TABLE)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else if (!st.enabled)
                    begin
                        cmd.emit_off = 1'b1;
                    end
                    else
                    begin
                        cmd.take_sample = 1'b1;
                        if (st.sample_ends)
                        begin
                            state_next = ST_RANK;
                        end
                    end
                end
            end
            ST_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (st.rank_found)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                if (st.ge_first)
                begin
                    cmd.ld_first = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.rd_sel = RS_LAST;
                    state_next = ST_RDL;
                end
            end
            ST_RDL:
            begin
                if (st.le_last)
                begin
                    cmd.ld_last = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.rd_sel = RS_ONE;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (st.srch_hit)
                begin
                    cmd.ld_hit = 1'b1;
                    cmd.rd_sel = RS_PREV;
                    state_next = ST_PREV;
                end
                else
                begin
                    cmd.rd_sel = RS_NEXT;
                end
            end
            ST_PREV:
            begin
                cmd.ld_prev = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    assign off_take  = (state_reg == ST_IDLE) && start && (command == CMD_SAMPLE)
                       && !st.enabled;
    assign last_take = start && (command == CMD_SAMPLE) && st.sample_ends;

    `include "assert_macros.svh"

    `ASSERT_AT(a_off_stays_idle, off_take |=> (state_reg == ST_IDLE))
    `ASSERT_AT(a_busy_needs_last_sample, $fell(state_reg == ST_IDLE) |-> $past(last_take))
    `ASSERT_NEVER(a_emit_in_idle, cmd.emit && (state_reg == ST_IDLE))
endmodule
`default_nettype wire

### hw/rtl/mtr_dp.sv
`default_nettype none
module mtr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mtr_pkg::item_t                item,
    input  wire logic                          cfg_we,
    input  wire logic [mtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mtr_pkg::CFG_W-1:0]     cfg_data,
    input  wire mtr_pkg::dp_cmd_t              cmd,
    output mtr_pkg::dp_stat_t                  st,
    output mtr_pkg::result_t                   result,
    output logic                               done
);
    import mtr_pkg::*;

    logic [CFG_W-1:0]  cnt_cfg_reg;
    logic              en_reg;
    logic [TSZ_W-1:0]  tsz_reg;

    logic [ADC_BITS-1:0] smp_reg [MAX_SAMPLES];
    logic [FILL_W-1:0]   fill_reg;
    logic [SIDX_W-1:0]   ci_reg;
    logic [ADC_BITS-1:0] med_reg;

    logic [ADC_BITS+TEMP_W-1:0] tab_mem [TABLE_DEPTH];
    logic [ADC_BITS+TEMP_W-1:0] ent_reg;
    logic [TIDX_W-1:0]          idx_reg;
    logic [TIDX_W-1:0]          rd_addr;

    logic [ADC_BITS-1:0]       xi_reg, xp_reg;
    logic signed [TEMP_W-1:0]  yi_reg, yp_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [ADC_BITS-1:0]       dsr_reg;
    logic [ADC_BITS-1:0]       rem_reg;
    logic                      neg_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic signed [TEMP_W-1:0]  t_reg;
    result_t                   result_reg;
    logic                      done_reg;

    logic [FILL_W-1:0]   n_samp;
    logic [FILL_W-1:0]   fill_inc;
    logic [TIDX_W-1:0]   last_idx;
    logic [ADC_BITS-1:0] cand;
    logic [FILL_W-1:0]   rank;
    logic [ADC_BITS-1:0] ent_x;
    logic signed [TEMP_W-1:0] ent_y;

    logic signed [TEMP_W:0]     dy;
    logic [ADC_BITS-1:0]        dxn;
    logic signed [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]          prod_mag;
    logic [ADC_BITS:0]          trial;
    logic                       qbit;
    logic signed [DVD_W+1:0]    q_s;
    logic signed [DVD_W+1:0]    v_s;
    logic signed [DVD_W+1:0]    half_s;
    logic signed [DVD_W+1:0]    t_s;

    // count clamped to 1..MAX_SAMPLES, last table index to 0..TABLE_DEPTH-1
    always_comb
    begin
        if (cnt_cfg_reg == '0)
        begin
            n_samp = FILL_W'(1);
        end
        else if (cnt_cfg_reg > CFG_W'(MAX_SAMPLES))
        begin
            n_samp = FILL_W'(MAX_SAMPLES);
        end
        else
        begin
            n_samp = FILL_W'(cnt_cfg_reg);
        end
        if (tsz_reg == '0)
        begin
            last_idx = '0;
        end
        else if (tsz_reg > TSZ_W'(TABLE_DEPTH))
        begin
            last_idx = TIDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = TIDX_W'(tsz_reg - TSZ_W'(1));
        end
    end

    assign fill_inc = (fill_reg < FILL_W'(MAX_SAMPLES)) ? fill_reg + FILL_W'(1)
                                                        : FILL_W'(MAX_SAMPLES);

    // rank of the candidate among the filled samples, ties broken by position
    assign cand = smp_reg[ci_reg];
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < MAX_SAMPLES; j++)
        begin
            if ((FILL_W'(j) < fill_reg) &&
                ((smp_reg[j] < cand) || ((SIDX_W'(j) < ci_reg) && (smp_reg[j] == cand))))
            begin
                rank = rank + FILL_W'(1);
            end
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RS_FIRST: rd_addr = '0;
            RS_LAST:  rd_addr = last_idx;
            RS_ONE:   rd_addr = TIDX_W'(1);
            RS_NEXT:  rd_addr = idx_reg + TIDX_W'(1);
            RS_PREV:  rd_addr = idx_reg - TIDX_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    assign ent_x = ent_reg[ADC_BITS+TEMP_W-1:TEMP_W];
    assign ent_y = ent_reg[TEMP_W-1:0];

    assign st.enabled     = en_reg;
    assign st.sample_ends = (fill_inc >= n_samp);
    assign st.rank_found  = (rank == (fill_reg >> 1));
    assign st.ge_first    = (med_reg >= ent_x);
    assign st.le_last     = (med_reg <= ent_x);
    assign st.srch_hit    = (med_reg > ent_x) || (idx_reg == last_idx);
    assign st.div_done    = (dcnt_reg == DCNT_W'(DVD_W - 1));

    assign dy       = (TEMP_W+1)'(yp_reg) - (TEMP_W+1)'(yi_reg);
    assign dxn      = med_reg - xi_reg;
    assign prod     = PROD_W'(dy) * $signed({1'b0, dxn});
    assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    // round: (q + 1) / 2 toward zero, then offset by the lower point
    always_comb
    begin
        q_s    = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
        v_s    = q_s + (DVD_W+2)'(1);
        half_s = v_s[DVD_W+1] ? -((-v_s) >>> 1) : (v_s >>> 1);
        t_s    = half_s + (DVD_W+2)'(yi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_cfg_reg <= CFG_W'(15);
            en_reg      <= 1'b1;
            tsz_reg     <= TSZ_W'(1);
            fill_reg    <= '0;
            ci_reg      <= '0;
            idx_reg     <= '0;
            dcnt_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit || cmd.emit_off;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_COUNT:  cnt_cfg_reg <= cfg_data;
                    REG_SENSOR_ENABLE: en_reg      <= cfg_data[0];
                    REG_TABLE_SIZE:    tsz_reg     <= TSZ_W'(cfg_data);
                    default:           ;
                endcase
            end
            if (cmd.take_sample)
            begin
                fill_reg <= fill_inc;
                ci_reg   <= '0;
            end
            if (cmd.rank_step)
            begin
                if (st.rank_found)
                begin
                    fill_reg <= '0;
                end
                else
                begin
                    ci_reg <= ci_reg + SIDX_W'(1);
                end
            end
            if (cmd.rd_sel == RS_ONE || cmd.rd_sel == RS_NEXT)
            begin
                idx_reg <= rd_addr;
            end
            if (cmd.mul)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample && (fill_reg < FILL_W'(MAX_SAMPLES)))
        begin
            smp_reg[SIDX_W'(fill_reg)] <= item.sample;
        end
        if (cmd.rank_step && st.rank_found)
        begin
            med_reg <= cand;
        end
        if (cmd.write_entry)
        begin
            tab_mem[item.entry_index[TIDX_W-1:0]] <= {item.entry_x, item.entry_y};
        end
        ent_reg <= tab_mem[rd_addr];
        if (cmd.ld_hit)
        begin
            xi_reg <= ent_x;
            yi_reg <= ent_y;
        end
        if (cmd.ld_prev)
        begin
            xp_reg <= ent_x;
            yp_reg <= ent_y;
        end
        if (cmd.mul)
        begin
            dvd_reg <= {prod_mag[DVD_W-2:0], 1'b0};
            neg_reg <= prod[PROD_W-1];
            dsr_reg <= xp_reg - xi_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? ADC_BITS'(trial - {1'b0, dsr_reg}) : trial[ADC_BITS-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
        end
        if (cmd.ld_first || cmd.ld_last)
        begin
            t_reg <= ent_y;
        end
        else if (cmd.calc)
        begin
            if (t_s > (DVD_W+2)'(32767))
            begin
                t_reg <= 16'sd32767;
            end
            else if (t_s < -(DVD_W+2)'(32768))
            begin
                t_reg <= -16'sd32768;
            end
            else
            begin
                t_reg <= t_s[TEMP_W-1:0];
            end
        end
        if (cmd.emit)
        begin
            result_reg.temperature <= t_reg;
            result_reg.median      <= med_reg;
        end
        else if (cmd.emit_off)
        begin
            result_reg.temperature <= OFF_TEMPERATURE;
            result_reg.median      <= OFF_MEDIAN;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_fill_bound, fill_reg > FILL_W'(MAX_SAMPLES))
    `ASSERT_AT(a_emit_strobe, (cmd.emit || cmd.emit_off) |=> done_reg)
    `ASSERT_AT(a_div_len, cmd.mul |=> (dcnt_reg == '0))
endmodule
`default_nettype wire

### hw/rtl/median_table_thermistor_reader.sv
`default_nettype none
// Burst-median thermistor reader. Pulse start with item.command = 0 to write
// one point {entry_x, entry_y} of the interpolation table (x descending with
// index), or with command = 1 to deliver one ADC sample. An item is taken on
// a clock edge where start is high and busy is low. Samples are gathered
// until the burst reaches the configured count (clamped to 1..15); the last
// sample raises busy while the burst is ranked (one candidate per cycle),
// the table is walked one entry per cycle through its single read port, and
// the interval slope goes through a 30-step restoring divider (one quotient
// bit per cycle). Ends-of-table hits skip the divider. Table writes and
// non-final samples never raise busy. With the sensor disabled each sample
// answers at once with temperature -35 and median 3000 and leaves the burst
// alone. done is a one-cycle strobe with result valid alongside it: the
// receiver cannot stall, so it must capture result on that cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once and belong
// in idle periods only.
module median_table_thermistor_reader (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire mtr_pkg::item_t                item,
    output logic                               done,
    output mtr_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [mtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mtr_pkg::CFG_W-1:0]     cfg_data
);
    import mtr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;

    // sequencer: walks rank, table search, divide, round
    mtr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .st      (st),
        .cmd     (cmd),
        .busy    (busy)
    );

    // burst store, table memory, ranker, divider and result register
    mtr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .result    (result),
        .done      (done)
    );
endmodule
`default_nettype wire

### sim/mtr_checker.sv
`timescale 1ns / 1ps
// Watches the item, config and result channels of the thermistor reader,
// predicts each result and compares it with what the block delivers.
module mtr_checker
    import mtr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  item_t                item,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);
    // configuration shadow
    logic [4:0] count_reg;
    logic       enable_reg;
    logic [4:0] size_reg;

    // block state shadow
    logic [ADC_BITS-1:0]      burst[MAX_SAMPLES];
    int                       fill;
    logic [ADC_BITS-1:0]      pt_x[TABLE_DEPTH];
    logic signed [TEMP_W-1:0] pt_y[TABLE_DEPTH];

    result_t readings_q[$];

    // piecewise-linear lookup, x descending with index, clamped at both ends
    function automatic logic signed [TEMP_W-1:0] lookup(logic [ADC_BITS-1:0] med);
        int     n;
        int     i;
        longint q;
        longint t;
        longint x;
        n = (size_reg < 1) ? 1 : (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
        x = med;
        if (x >= longint'(pt_x[0]))
            t = pt_y[0];
        else if (x <= longint'(pt_x[n-1]))
            t = pt_y[n-1];
        else
        begin
            for (i = 1; i < n - 1; i++)
                if (x > longint'(pt_x[i])) break;
            q = (longint'(pt_y[i-1]) - longint'(pt_y[i])) * (x - longint'(pt_x[i])) * 2;
            q = q / (longint'(pt_x[i-1]) - longint'(pt_x[i]));
            t = (q + 1) / 2 + longint'(pt_y[i]);
        end
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[TEMP_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [ADC_BITS-1:0] sorted[$];
        int                  n;
        result_t             r;
        if (!rst_n)
        begin
            count_reg  = 5'd15;
            enable_reg = 1'b1;
            size_reg   = 5'd1;
            fill       = 0;
            foreach (pt_x[k])
            begin
                pt_x[k] = '0;
                pt_y[k] = '0;
            end
            readings_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_COUNT:  count_reg  = cfg_data[4:0];
                    REG_SENSOR_ENABLE: enable_reg = cfg_data[0];
                    REG_TABLE_SIZE:    size_reg   = cfg_data[4:0];
                    default: ;
                endcase
            end
            // predict first so a same-cycle answer would still find its entry
            if (start && !busy)
            begin
                if (item.command == CMD_TABLE)
                begin
                    pt_x[item.entry_index] = item.entry_x;
                    pt_y[item.entry_index] = item.entry_y;
                end
                else if (!enable_reg)
                begin
                    r.temperature = OFF_TEMPERATURE;
                    r.median      = OFF_MEDIAN;
                    readings_q.push_back(r);
                end
                else
                begin
                    n = (count_reg < 1) ? 1 :
                        (count_reg > MAX_SAMPLES) ? MAX_SAMPLES : int'(count_reg);
                    if (fill < MAX_SAMPLES) burst[fill] = item.sample;
                    fill++;
                    if (fill > MAX_SAMPLES) fill = MAX_SAMPLES;
                    if (fill >= n)
                    begin
                        sorted.delete();
                        for (int k = 0; k < fill; k++) sorted.push_back(burst[k]);
                        sorted.sort();
                        r.median      = sorted[fill / 2];
                        r.temperature = lookup(r.median);
                        fill = 0;
                        readings_q.push_back(r);
                    end
                end
            end
            if (done)
            begin
                if (readings_q.size() == 0)
                begin
                    $error("result with no reading expected");
                    fail_count++;
                end
                else
                begin
                    r = readings_q.pop_front();
                    if (result.temperature !== r.temperature)
                    begin
                        $error("temperature: expected %0d, got %0d",
                               r.temperature, result.temperature);
                        fail_count++;
                    end
                    if (result.median !== r.median)
                    begin
                        $error("median: expected %0d, got %0d", r.median, result.median);
                        fail_count++;
                    end
                end
            end
            pending <= readings_q.size();
        end
    end
endmodule

### sim/median_table_thermistor_reader_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the thermistor reader; all checking lives in mtr_checker.
module median_table_thermistor_reader_tb;
    import mtr_pkg::*;

    localparam int STALL_LIMIT = 2000;  // idle cycles before the run is declared hung
    localparam int SETTLE      = 90;    // longer than the worst burst-end latency

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    item_t                item = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SAMPLE_COUNT;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   quiet_cycles = 0;

    // our copy of table x values, used to aim samples near breakpoints
    logic [ADC_BITS-1:0]  aim_x[TABLE_DEPTH];

    always #5 clk = ~clk;

    median_table_thermistor_reader uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    mtr_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: any accepted item or delivered result resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("median_table_thermistor_reader test failed");
            $finish;
        end
    end

    // Hold start high and wait for the edge that takes the item. start stays
    // high afterwards so back-to-back items need no extra NBA on it.
    task automatic push_item(input item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic table_write(input int idx, input int x, input int y);
        item_t it;
        it = item_t'({$urandom, $urandom});  // unused fields random
        it.command     = CMD_TABLE;
        it.entry_index = idx[3:0];
        it.entry_x     = x[ADC_BITS-1:0];
        it.entry_y     = y[TEMP_W-1:0];
        aim_x[idx[3:0]] = x[ADC_BITS-1:0];
        push_item(it);
    endtask

    task automatic adc_sample(input int s);
        item_t it;
        it = item_t'({$urandom, $urandom});
        it.command = CMD_SAMPLE;
        it.sample  = s[ADC_BITS-1:0];
        push_item(it);
    endtask

    // Sender quiet, all readings in, then margin for a burst still ranking.
    task automatic drain();
        pause_sender(1);
        while (pending != 0 || busy) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Fill 'n' entries with a descending curve of random shape; now and then
    // a scrambled entry to exercise non-monotonic lookups.
    task automatic load_curve(input int n);
        int x;
        int stepw;
        stepw = 4096 / n;
        x = 4095 - $urandom_range(0, stepw / 4);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                table_write(k, $urandom_range(0, 4095), $urandom);
            else
                table_write(k, x, $urandom_range(0, 3) == 0 ? $urandom
                                  : $urandom_range(0, 400) - 200 + k * 37);
            x = x - stepw + $urandom_range(0, stepw / 3);
            if (x < 0) x = 0;
        end
    endtask

    function automatic int pick_sample(input int n);
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 4095 : 0;
            1, 2: return (int'(aim_x[$urandom_range(0, n - 1)]) + $urandom_range(0, 6) - 3) & 12'hFFF;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    initial
    begin
        int cnt_choice;
        int size_choice;
        int n_eff;
        int burst_left;
        foreach (aim_x[k]) aim_x[k] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // whole table defined up front so no lookup reads an unset entry
        for (int k = 0; k < TABLE_DEPTH; k++)
            table_write(15 - k, k * 273, k * 100 - 800);
        table_write(0, 4000, -32768);
        table_write(1, 3000, 250);
        table_write(2, 1000, 32767);
        table_write(3, 0, -1);
        drain();
        reg_write(REG_TABLE_SIZE, 4);
        reg_write(REG_SAMPLE_COUNT, 1);
        adc_sample(4095);   // above first point: clamp to first y
        adc_sample(0);      // at last point: clamp to last y
        adc_sample(2000);   // interior interval
        adc_sample(3500);   // steep negative-to-positive slope
        adc_sample(500);
        drain();
        reg_write(REG_SAMPLE_COUNT, 0);    // clamps to one sample
        adc_sample(3000);                   // exactly on a breakpoint
        drain();
        // count lowered while a burst is half collected
        reg_write(REG_SAMPLE_COUNT, 31);
        adc_sample(12); adc_sample(4095); adc_sample(700); adc_sample(2500);
        drain();
        reg_write(REG_SAMPLE_COUNT, 3);
        // disabled sensor answers at once and leaves the partial burst alone
        reg_write(REG_SENSOR_ENABLE, 0);
        adc_sample(0);
        adc_sample(4095);
        drain();
        reg_write(REG_SENSOR_ENABLE, 1);
        adc_sample(1500);   // closes the five-sample burst
        drain();

        // ---- random phases; each boundary waits for every reading ----
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: cnt_choice = 31;
                1: cnt_choice = 0;
                2: cnt_choice = 15;
                default: cnt_choice = ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 31) : $urandom_range(1, 5);
            endcase
            case (ph)
                0: size_choice = 31;
                1: size_choice = 0;
                2: size_choice = 16;
                3: size_choice = 2;
                default: size_choice = $urandom_range(0, 31);
            endcase
            n_eff = (size_choice < 1) ? 1 :
                    (size_choice > TABLE_DEPTH) ? TABLE_DEPTH : size_choice;
            reg_write(REG_SAMPLE_COUNT, cnt_choice);
            reg_write(REG_TABLE_SIZE, size_choice);
            reg_write(REG_SENSOR_ENABLE, (ph == 6) ? 0 : 1);
            load_curve(n_eff);

            burst_left = 0;
            for (int k = 0; k < 32; k++)
            begin
                // sender bursts with random gaps; some phases run gap-free
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if (ph % 4 != 3) pause_sender($urandom_range(1, 15));
                end
                burst_left--;
                if ($urandom_range(0, 9) == 0)
                    table_write($urandom_range(0, 15), $urandom_range(0, 4095), $urandom);
                else
                    adc_sample(pick_sample(n_eff));
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("median_table_thermistor_reader test passed");
        else
            $display("median_table_thermistor_reader test failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mtr_pkg.sv
hw/rtl/mtr_ctrl.sv
hw/rtl/mtr_dp.sv
hw/rtl/median_table_thermistor_reader.sv
sim/mtr_checker.sv
sim/median_table_thermistor_reader_tb.sv
